// ===== hw/rtl/esd_pkg.sv =====
// shared types for the escape sequence decoder
package esd_pkg;

   // decoder phase between input transfers
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ESC   = 2'd1,
      PH_LEAD  = 2'd2,
      PH_DIGIT = 2'd3
   } phase_type;

   // one input item
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_payload_type;

   // up to three decoded bytes caused by one input item, byte 0 goes out first
   typedef struct packed {
      logic [1:0]      count;
      logic            last;
      logic [2:0][7:0] bytes;
   } burst_type;

   localparam logic [1:0] BURST_MAX = 2'd3;

endpackage

// ===== hw/rtl/esd_decode.sv =====
// escape state registers and the per-byte decode into a result burst
module esd_decode import esd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req_payload,
   output burst_type       burst
);

   localparam logic [7:0] CHAR_BSLASH = 8'd92;
   localparam logic [7:0] CHAR_X      = 8'd120;
   localparam logic [7:0] CHAR_ZERO   = 8'd48;
   localparam logic [7:0] CHAR_THREE  = 8'd51;
   localparam logic [7:0] CHAR_NINE   = 8'd57;
   localparam logic [7:0] CHAR_SEVEN  = 8'd55;
   localparam logic [7:0] CHAR_UA     = 8'd65;
   localparam logic [7:0] CHAR_UF     = 8'd70;
   localparam logic [7:0] CHAR_LA     = 8'd97;
   localparam logic [7:0] CHAR_LF     = 8'd102;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_lead_ff, held_lead_in;
   logic [7:0] held_digit_ff, held_digit_in;

   function automatic logic is_hex(logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UA && c <= CHAR_UF) ||
             (c >= CHAR_LA && c <= CHAR_LF);
   endfunction

   function automatic logic is_oct(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_SEVEN;
   endfunction

   // digit value of a character already known to be hex
   function automatic logic [3:0] hex_val(logic [7:0] c);
      return (c <= CHAR_NINE) ? c[3:0] : 4'(c[3:0] + 4'd9);
   endfunction

   // append one byte to a burst, bytes past the third are dropped
   function automatic burst_type push(burst_type bi, logic [7:0] b);
      burst_type bo;
      bo = bi;
      if (bi.count != BURST_MAX) begin
         bo.bytes[bi.count] = b;
         bo.count = 2'(bi.count + 2'd1);
      end
      return bo;
   endfunction

   // decode of the current byte against the pending escape
   always_comb begin
      logic [7:0] b;
      burst_type  r;
      b             = req_payload.in_byte;
      r             = '0;
      phase_in      = PH_IDLE;
      held_lead_in  = held_lead_ff;
      held_digit_in = held_digit_ff;
      case (phase_ff)
         PH_ESC: begin
            case (b)
               CHAR_BSLASH: r = push(r, CHAR_BSLASH);
               8'd97:       r = push(r, 8'd7);
               8'd115:      r = push(r, 8'd32);
               8'd110:      r = push(r, 8'd10);
               8'd114:      r = push(r, 8'd13);
               8'd116:      r = push(r, 8'd9);
               8'd118:      r = push(r, 8'd11);
               default: begin
                  if (b == CHAR_X || (b >= CHAR_ZERO && b <= CHAR_THREE)) begin
                     held_lead_in = b;
                     phase_in     = PH_LEAD;
                  end else begin
                     r = push(r, CHAR_BSLASH);
                     r = push(r, b);
                  end
               end
            endcase
         end
         PH_LEAD: begin
            if (is_hex(b)) begin
               held_digit_in = b;
               phase_in      = PH_DIGIT;
            end else begin
               r = push(r, held_lead_ff);
               if (b == CHAR_BSLASH) phase_in = PH_ESC;
               else r = push(r, b);
            end
         end
         PH_DIGIT: begin
            if (!is_hex(b)) begin
               r = push(r, held_lead_ff);
               r = push(r, held_digit_ff);
               if (b == CHAR_BSLASH) phase_in = PH_ESC;
               else r = push(r, b);
            end else if (held_lead_ff == CHAR_X) begin
               r = push(r, {hex_val(held_digit_ff), hex_val(b)});
            end else if (is_oct(held_digit_ff) && is_oct(b)) begin
               r = push(r, {held_lead_ff[1:0], held_digit_ff[2:0], b[2:0]});
            end else begin
               r = push(r, held_lead_ff);
               r = push(r, held_digit_ff);
               r = push(r, b);
            end
         end
         default: begin
            if (b == CHAR_BSLASH) phase_in = PH_ESC;
            else r = push(r, b);
         end
      endcase
      // end of string flushes whatever escape is still open
      if (req_payload.in_last) begin
         case (phase_in)
            PH_ESC:   r = push(r, CHAR_BSLASH);
            PH_LEAD:  r = push(r, held_lead_in);
            PH_DIGIT: begin
               r = push(r, held_lead_in);
               r = push(r, held_digit_in);
            end
            default: ;
         endcase
         phase_in = PH_IDLE;
         r.last   = (r.count != 2'd0);
      end
      burst = r;
   end

   // escape state advances on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         held_lead_ff  <= '0;
         held_digit_ff <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         held_lead_ff  <= held_lead_in;
         held_digit_ff <= held_digit_in;
      end
   end

endmodule

// ===== hw/rtl/esd_drain.sv =====
// result buffer that holds one burst and sends it out a byte per transfer
module esd_drain import esd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  burst_type       burst,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   output logic            room
);

   logic [1:0]      cnt_ff, cnt_in;
   logic            last_ff, last_in;
   logic [2:0][7:0] bytes_ff, bytes_in;
   logic            rsp_xfer;

   assign rsp_valid            = (cnt_ff != 2'd0);
   assign rsp_xfer             = rsp_valid && !rsp_stall;
   assign rsp_payload.out_byte = bytes_ff[0];
   assign rsp_payload.out_last = last_ff && (cnt_ff == 2'd1);

   // free for a new burst when empty or when the final byte leaves now
   assign room = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_xfer);

   // load a new burst or shift the next byte to the front
   always_comb begin
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      bytes_in = bytes_ff;
      if (load) begin
         cnt_in   = burst.count;
         last_in  = burst.last;
         bytes_in = burst.bytes;
      end else if (rsp_xfer) begin
         cnt_in   = 2'(cnt_ff - 2'd1);
         bytes_in = {8'h00, bytes_ff[2], bytes_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         last_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   // a burst never overwrites bytes that are still to go out
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && rsp_xfer)))
      else $error("burst loaded over pending results");

   // empty bursts are never loaded
   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      load |-> burst.count != 2'd0)
      else $error("empty burst loaded");

   // the final byte leaving with no new load empties the buffer
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && cnt_ff == 2'd1 && !load) |=> cnt_ff == 2'd0)
      else $error("buffer not empty after final transfer");

endmodule

// ===== hw/rtl/escape_sequence_decoder.sv =====
// top level of the backslash escape sequence decoder
// Usage:
//   req channel: one character per transfer (req_payload.in_byte, in_last marks
//   the final character of a string). rsp channel: decoded bytes, one per
//   transfer, out_last on the final decoded byte of each string.
//   Escapes: \\ \a \s \n \r \t \v, \xHH and \ODD with a lead of 0 to 3; an
//   unfinished \x or \ODD falls back to literals without the backslash.
// Latency: a character's first result is offered the cycle after its transfer.
// Throughput: one character per cycle while each causes at most one result
//   and rsp_stall is low; after a character that causes two or three results,
//   req_stall is held while the result buffer drains one byte per transfer
//   down to its final byte. Characters that only open or extend an escape
//   produce nothing and never stall on their own.
// Reset: the escape state goes idle and the result buffer is emptied.
// Receiver stall: the pending result holds on rsp_payload, and once the buffer
//   cannot take the next burst, req_stall is raised and the input waits.
module escape_sequence_decoder import esd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic      accept;
   logic      room;
   burst_type burst;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   esd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .burst       (burst)
   );

   esd_drain u_drain (
      .clock       (clock),
      .reset       (reset),
      .load        (accept && (burst.count != 2'd0)),
      .burst       (burst),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .room        (room)
   );

endmodule
